>>> rtl/assert_macros.svh
// Assertion macros shared by the level meter RTL.
// Each macro expects aclk and aresetn to be visible in the calling module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

>>> rtl/vwlm_pkg.sv
// Shared types and constants for the voiced window level meter.
// No dependencies; imported by vwlm_ctrl, vwlm_datapath and the top level.
`timescale 1ns / 1ps

package vwlm_pkg;

    localparam int WINDOWS_NEEDED = 16;
    localparam int SAMPLE_BITS    = 24;

    // field widths
    localparam int FUNC_W    = 2;
    localparam int SAMPLE_W  = 24;
    localparam int MODE_W    = 2;
    localparam int KCNT_W    = 7;
    localparam int SUM_W     = 62;
    localparam int LEN_W     = 16;
    localparam int CREST_W   = 16;

    // stream packing
    localparam int S_TDATA_W = 2 * SAMPLE_W;
    localparam int S_TUSER_W = FUNC_W + 1;
    localparam int M_FIELD_W = MODE_W + KCNT_W + SUM_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = SUM_W;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FLOOR_SUM     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CREST_RATIO   = 2'd2;

    localparam logic [LEN_W-1:0]   WINDOW_LENGTH_RST = 16'd2048;
    localparam logic [CREST_W-1:0] CREST_RATIO_RST   = 16'd2560;

    // datapath arithmetic
    localparam int PSQ_W       = 2 * SAMPLE_BITS;        // squared magnitude
    localparam int PSQ_HALF_W  = SAMPLE_BITS;
    localparam int SUM_HALF_W  = (SUM_W + 1) / 2;
    localparam int MUL_A_W     = SUM_HALF_W;
    localparam int MUL_B_W     = SAMPLE_BITS;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int CREST_FRAC  = 8;                      // Q8.8 ratio
    localparam int LHS_W       = PSQ_W + LEN_W;
    localparam int RHS_W       = SUM_W + CREST_W;

    // kept window store and median walk
    localparam int KIDX_W      = (WINDOWS_NEEDED > 1) ? $clog2(WINDOWS_NEEDED) : 1;
    localparam int SCNT_W      = $clog2(WINDOWS_NEEDED + 1) + 1;
    localparam int MEDIAN_RANK = WINDOWS_NEEDED / 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_FRAME  = 2'd0,
        FUNC_START  = 2'd1,
        FUNC_CANCEL = 2'd2,
        FUNC_TAKE   = 2'd3
    } func_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE   = 2'd0,
        MODE_LISTEN = 2'd1,
        MODE_DONE   = 2'd2
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SQ_R,
        ST_SQ_SUM,
        ST_FRAME,
        ST_WIN_TEST,
        ST_CREST1,
        ST_CREST2,
        ST_CREST3,
        ST_CREST4,
        ST_CREST5,
        ST_DECIDE,
        ST_KEPT_TEST,
        ST_MED_LOAD,
        ST_MED_CAND,
        ST_MED_SCAN,
        ST_MED_TEST,
        ST_RESULT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_START,
        OP_CANCEL,
        OP_TAKE,
        OP_SQ_L,
        OP_SQ_R,
        OP_SQ_SUM,
        OP_FRAME,
        OP_PK_SQ,
        OP_CREST1,
        OP_CREST2,
        OP_CREST3,
        OP_CREST4,
        OP_CREST5,
        OP_DECIDE,
        OP_MED_INIT,
        OP_MED_LOAD,
        OP_MED_CAND,
        OP_MED_SCAN,
        OP_MED_STORE,
        OP_MED_NEXT,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        func_t func;
        logic  listening;
        logic  win_full;
        logic  kept_full;
        logic  scan_last;
        logic  med_hit;
        logic  med_last;
        logic  out_free;
    } dp_status_t;

endpackage

>>> rtl/vwlm_datapath.sv
// Datapath of the level meter: config registers, window accumulators,
// shared multiplier, kept-sum memory with median walk, and result register.
// Depends on vwlm_pkg and assert_macros.svh; driven by op codes from vwlm_ctrl.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vwlm_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [vwlm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [vwlm_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic [vwlm_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [vwlm_pkg::S_TUSER_W-1:0]   s_tuser,
    input  vwlm_pkg::dp_op_t                 op,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [vwlm_pkg::M_TDATA_W-1:0]   m_tdata,
    output vwlm_pkg::dp_status_t             status
);
    import vwlm_pkg::*;

    function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS-1:0] neg;
        neg = (~v) + {{(SAMPLE_BITS-1){1'b0}}, 1'b1};
        return v[SAMPLE_BITS-1] ? neg : v;
    endfunction

    // configuration
    logic [LEN_W-1:0]   win_len_reg;
    logic [SUM_W-1:0]   floor_reg;
    logic [CREST_W-1:0] crest_reg;

    // captured item
    func_t                  func_reg;
    logic [SAMPLE_BITS-1:0] left_reg, right_reg;
    logic                   invalid_reg;

    // control-like state
    mode_t              mode_reg, mode_next;
    logic [SUM_W-1:0]   ps_reg, ps_next;
    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    logic [LEN_W-1:0]   frame_count_reg, frame_count_next;
    logic               bad_reg, bad_next;
    logic [KCNT_W-1:0]  kept_reg, kept_next;
    logic [SUM_W-1:0]   median_reg, median_next;
    logic               out_valid_reg, out_valid_next;

    // payload / scratch
    logic [PROD_W-1:0]  prod_reg;
    logic [PSQ_W:0]     sq_reg, sq_next;
    logic [PSQ_W-1:0]   psq_reg, psq_next;
    logic [LHS_W-1:0]   lhs_reg, lhs_next;
    logic [RHS_W-1:0]   rhs_reg, rhs_next;
    logic [SUM_W-1:0]   cand_reg, cand_next;
    logic [KIDX_W-1:0]  med_i_reg, med_i_next;
    logic [SCNT_W-1:0]  med_j_reg, med_j_next;
    logic [SCNT_W-1:0]  lt_reg, lt_next, le_reg, le_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [SUM_W-1:0]   kept_mem [WINDOWS_NEEDED];
    logic [SUM_W-1:0]   rd_data_reg;
    logic [KIDX_W-1:0]  rd_addr;
    logic               mem_we;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;

    logic [SAMPLE_BITS-1:0] mag_l, mag_r, peak_l;
    logic [SUM_W:0]         ps_sum;
    logic [LEN_W-1:0]       len_eff;
    logic                   crest_ok, keep;

    assign mag_l   = magnitude(left_reg);
    assign mag_r   = magnitude(right_reg);
    assign peak_l  = (mag_l > peak_reg) ? mag_l : peak_reg;
    assign ps_sum  = {1'b0, ps_reg} + (SUM_W + 1)'(sq_reg[PSQ_W:1]);
    assign len_eff = (win_len_reg == '0) ? LEN_W'(1) : win_len_reg;
    // peak^2 * n * 256 <= crest * power_sum
    assign crest_ok = RHS_W'({lhs_reg, {CREST_FRAC{1'b0}}}) <= rhs_reg;
    assign keep     = !bad_reg && (ps_reg > floor_reg) && crest_ok
                      && (kept_reg < KCNT_W'(WINDOWS_NEEDED));

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_SQ_L: begin
                mul_a = MUL_A_W'(mag_l);
                mul_b = MUL_B_W'(mag_l);
            end
            OP_SQ_R: begin
                mul_a = MUL_A_W'(mag_r);
                mul_b = MUL_B_W'(mag_r);
            end
            OP_PK_SQ: begin
                mul_a = MUL_A_W'(peak_reg);
                mul_b = MUL_B_W'(peak_reg);
            end
            OP_CREST1: begin
                mul_a = ps_reg[SUM_HALF_W-1:0];
                mul_b = MUL_B_W'(crest_reg);
            end
            OP_CREST2: begin
                mul_a = MUL_A_W'(ps_reg[SUM_W-1:SUM_HALF_W]);
                mul_b = MUL_B_W'(crest_reg);
            end
            OP_CREST3: begin
                mul_a = MUL_A_W'(psq_reg[PSQ_HALF_W-1:0]);
                mul_b = MUL_B_W'(frame_count_reg);
            end
            OP_CREST4: begin
                mul_a = MUL_A_W'(psq_reg[PSQ_W-1:PSQ_HALF_W]);
                mul_b = MUL_B_W'(frame_count_reg);
            end
            default: ;
        endcase
    end

    always_comb begin
        mode_next        = mode_reg;
        ps_next          = ps_reg;
        peak_next        = peak_reg;
        frame_count_next = frame_count_reg;
        bad_next         = bad_reg;
        kept_next        = kept_reg;
        median_next      = median_reg;
        sq_next          = sq_reg;
        psq_next         = psq_reg;
        lhs_next         = lhs_reg;
        rhs_next         = rhs_reg;
        cand_next        = cand_reg;
        med_i_next       = med_i_reg;
        med_j_next       = med_j_reg;
        lt_next          = lt_reg;
        le_next          = le_reg;
        rd_addr          = med_j_reg[KIDX_W-1:0];
        mem_we           = 1'b0;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;

        case (op)
            OP_START: begin
                kept_next        = '0;
                ps_next          = '0;
                peak_next        = '0;
                frame_count_next = '0;
                bad_next         = 1'b0;
                mode_next        = MODE_LISTEN;
            end
            OP_CANCEL: begin
                if (mode_reg == MODE_LISTEN) begin
                    mode_next = MODE_IDLE;
                end
            end
            OP_TAKE: mode_next = MODE_IDLE;
            OP_SQ_R: sq_next = (PSQ_W + 1)'(prod_reg);
            OP_SQ_SUM: sq_next = sq_reg + (PSQ_W + 1)'(prod_reg);
            OP_FRAME: begin
                ps_next          = ps_sum[SUM_W] ? '1 : ps_sum[SUM_W-1:0];
                peak_next        = (mag_r > peak_l) ? mag_r : peak_l;
                bad_next         = bad_reg | invalid_reg;
                frame_count_next = frame_count_reg + LEN_W'(1);
            end
            OP_CREST1: psq_next = prod_reg[PSQ_W-1:0];
            OP_CREST2: rhs_next = RHS_W'(prod_reg);
            OP_CREST3: rhs_next = rhs_reg + (RHS_W'(prod_reg) << SUM_HALF_W);
            OP_CREST4: lhs_next = LHS_W'(prod_reg);
            OP_CREST5: lhs_next = lhs_reg + (LHS_W'(prod_reg) << PSQ_HALF_W);
            OP_DECIDE: begin
                if (keep) begin
                    mem_we    = 1'b1;
                    kept_next = kept_reg + KCNT_W'(1);
                end
                ps_next          = '0;
                peak_next        = '0;
                frame_count_next = '0;
                bad_next         = 1'b0;
            end
            OP_MED_INIT: med_i_next = '0;
            OP_MED_LOAD: begin
                rd_addr    = med_i_reg;
                med_j_next = '0;
                lt_next    = '0;
                le_next    = '0;
            end
            OP_MED_CAND: begin
                cand_next  = rd_data_reg;
                med_j_next = med_j_reg + SCNT_W'(1);
            end
            OP_MED_SCAN: begin
                // rd_data_reg holds entry med_j_reg - 1
                if (rd_data_reg < cand_reg) begin
                    lt_next = lt_reg + SCNT_W'(1);
                end
                if (rd_data_reg <= cand_reg) begin
                    le_next = le_reg + SCNT_W'(1);
                end
                med_j_next = med_j_reg + SCNT_W'(1);
            end
            OP_MED_STORE: begin
                median_next = cand_reg;
                mode_next   = MODE_DONE;
            end
            OP_MED_NEXT: med_i_next = med_i_reg + KIDX_W'(1);
            OP_RESULT: begin
                out_valid_next = 1'b1;
                out_data_next  = {{M_PAD_W{1'b0}}, median_reg, kept_reg, mode_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg     <= WINDOW_LENGTH_RST;
            floor_reg       <= '0;
            crest_reg       <= CREST_RATIO_RST;
            mode_reg        <= MODE_IDLE;
            ps_reg          <= '0;
            peak_reg        <= '0;
            frame_count_reg <= '0;
            bad_reg         <= 1'b0;
            kept_reg        <= '0;
            median_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_WINDOW_LENGTH: win_len_reg <= cfg_wr_data[LEN_W-1:0];
                    REG_FLOOR_SUM:     floor_reg   <= cfg_wr_data[SUM_W-1:0];
                    REG_CREST_RATIO:   crest_reg   <= cfg_wr_data[CREST_W-1:0];
                    default: ;
                endcase
            end
            mode_reg        <= mode_next;
            ps_reg          <= ps_next;
            peak_reg        <= peak_next;
            frame_count_reg <= frame_count_next;
            bad_reg         <= bad_next;
            kept_reg        <= kept_next;
            median_reg      <= median_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (op == OP_CAPTURE) begin
            func_reg    <= func_t'(s_tuser[FUNC_W-1:0]);
            invalid_reg <= s_tuser[FUNC_W];
            left_reg    <= s_tdata[SAMPLE_BITS-1:0];
            right_reg   <= s_tdata[SAMPLE_W +: SAMPLE_BITS];
        end
        prod_reg     <= PROD_W'(mul_a) * PROD_W'(mul_b);
        sq_reg       <= sq_next;
        psq_reg      <= psq_next;
        lhs_reg      <= lhs_next;
        rhs_reg      <= rhs_next;
        cand_reg     <= cand_next;
        med_i_reg    <= med_i_next;
        med_j_reg    <= med_j_next;
        lt_reg       <= lt_next;
        le_reg       <= le_next;
        out_data_reg <= out_data_next;
    end

    // kept window sums
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            kept_mem[kept_reg[KIDX_W-1:0]] <= ps_reg;
        end
        rd_data_reg <= kept_mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign status.func      = func_reg;
    assign status.listening = (mode_reg == MODE_LISTEN);
    assign status.win_full  = (frame_count_reg >= len_eff);
    assign status.kept_full = (kept_reg == KCNT_W'(WINDOWS_NEEDED));
    assign status.scan_last = (med_j_reg == SCNT_W'(WINDOWS_NEEDED));
    assign status.med_hit   = (lt_reg <= SCNT_W'(MEDIAN_RANK))
                              && (SCNT_W'(MEDIAN_RANK) < le_reg);
    assign status.med_last  = (med_i_reg == KIDX_W'(WINDOWS_NEEDED - 1));
    assign status.out_free  = !out_valid_reg || m_tready;

    `ASSERT_CLK(a_done_has_all, (mode_reg == MODE_DONE) |-> status.kept_full, "done without full set")
    `ASSERT_NEVER(a_kept_range, kept_reg > KCNT_W'(WINDOWS_NEEDED), "kept count overrun")
    `ASSERT_CLK(a_decide_clears, (op == OP_DECIDE) |=> (frame_count_reg == '0 && ps_reg == '0 && !bad_reg), "window not cleared")

endmodule

>>> rtl/vwlm_ctrl.sv
// Sequencer of the level meter: one item at a time through decode, frame
// accumulate, window close and median walk. Depends on vwlm_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vwlm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  vwlm_pkg::dp_status_t status,
    output vwlm_pkg::dp_op_t     op
);
    import vwlm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_DECODE;
            ST_DECODE: begin
                if (status.func == FUNC_FRAME && status.listening) begin
                    state_next = ST_SQ_R;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_SQ_R:      state_next = ST_SQ_SUM;
            ST_SQ_SUM:    state_next = ST_FRAME;
            ST_FRAME:     state_next = ST_WIN_TEST;
            ST_WIN_TEST:  state_next = status.win_full ? ST_CREST1 : ST_RESULT;
            ST_CREST1:    state_next = ST_CREST2;
            ST_CREST2:    state_next = ST_CREST3;
            ST_CREST3:    state_next = ST_CREST4;
            ST_CREST4:    state_next = ST_CREST5;
            ST_CREST5:    state_next = ST_DECIDE;
            ST_DECIDE:    state_next = ST_KEPT_TEST;
            ST_KEPT_TEST: state_next = status.kept_full ? ST_MED_LOAD : ST_RESULT;
            ST_MED_LOAD:  state_next = ST_MED_CAND;
            ST_MED_CAND:  state_next = ST_MED_SCAN;
            ST_MED_SCAN:  if (status.scan_last) state_next = ST_MED_TEST;
            ST_MED_TEST: begin
                state_next = (status.med_hit || status.med_last) ? ST_RESULT : ST_MED_LOAD;
            end
            ST_RESULT:    if (status.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op = OP_NONE;
        unique case (state_reg)
            ST_IDLE:      op = s_tvalid ? OP_CAPTURE : OP_NONE;
            ST_DECODE: begin
                unique case (status.func)
                    FUNC_START:  op = OP_START;
                    FUNC_CANCEL: op = OP_CANCEL;
                    FUNC_TAKE:   op = OP_TAKE;
                    FUNC_FRAME:  op = status.listening ? OP_SQ_L : OP_NONE;
                    default:     op = OP_NONE;
                endcase
            end
            ST_SQ_R:      op = OP_SQ_R;
            ST_SQ_SUM:    op = OP_SQ_SUM;
            ST_FRAME:     op = OP_FRAME;
            ST_WIN_TEST:  op = OP_PK_SQ;
            ST_CREST1:    op = OP_CREST1;
            ST_CREST2:    op = OP_CREST2;
            ST_CREST3:    op = OP_CREST3;
            ST_CREST4:    op = OP_CREST4;
            ST_CREST5:    op = OP_CREST5;
            ST_DECIDE:    op = OP_DECIDE;
            ST_KEPT_TEST: op = OP_MED_INIT;
            ST_MED_LOAD:  op = OP_MED_LOAD;
            ST_MED_CAND:  op = OP_MED_CAND;
            ST_MED_SCAN:  op = OP_MED_SCAN;
            ST_MED_TEST: begin
                op = (status.med_hit || status.med_last) ? OP_MED_STORE : OP_MED_NEXT;
            end
            ST_RESULT:    op = status.out_free ? OP_RESULT : OP_NONE;
            default:      op = OP_NONE;
        endcase
    end

    // no item is taken while reset is held
    assign s_tready = aresetn && (state_reg == ST_IDLE);

    `ASSERT_CLK(a_accept_decode, (s_tvalid && s_tready) |=> (state_reg == ST_DECODE), "accept lost")
    `ASSERT_CLK(a_median_full, (state_reg == ST_MED_LOAD) |-> status.kept_full, "median walk on partial set")
    `ASSERT_CLK(a_result_free, (op == OP_RESULT) |-> status.out_free, "result overwritten")

endmodule

>>> rtl/voiced_window_level_meter_core.sv
// Top level of the voiced window level meter.
// Instantiates vwlm_ctrl and vwlm_datapath; types and constants from vwlm_pkg.
`timescale 1ns / 1ps

// One item is processed at a time and every item yields exactly one result
// (mode, kept window count, stored median sum). A command, or a frame while
// not listening, goes from decode straight to the result; a frame that does
// not close its window first squares and accumulates its samples; a frame that
// closes a window also runs the crest test through one shared 31x24 multiplier
// over five steps. The frame that completes the set of kept windows also runs
// the upper-median search over the kept-sum memory, one read port, one entry
// per cycle. The next item can be accepted as soon as a result is placed in
// the output register, even while that result is still waiting to be taken.
module voiced_window_level_meter_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration writes
    input  logic                             cfg_wr_en,
    input  logic [vwlm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [vwlm_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [vwlm_pkg::S_TDATA_W-1:0]   s_tdata,  // left_sample, right_sample
    input  logic [vwlm_pkg::S_TUSER_W-1:0]   s_tuser,  // func, sample_invalid
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [vwlm_pkg::M_TDATA_W-1:0]   m_tdata   // mode, windows_accepted, median_sum, pad
);
    import vwlm_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    vwlm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    vwlm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .op          (op),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .status      (status)
    );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for voiced_window_level_meter_core: directed table, then random
// listening sessions checked item by item against an in-bench level meter predictor.
// Depends on vwlm_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module testbench;
    import vwlm_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int PHASES        = 10;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int N_DIRECTED    = 20;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        mode_t              mode;
        logic [KCNT_W-1:0]  kept;
        logic [SUM_W-1:0]   median;
    } level_result_t;

    typedef struct {
        func_t                  func;
        logic [SAMPLE_W-1:0]    left;
        logic [SAMPLE_W-1:0]    right;
        logic                   invalid;
        bit                     typed;
        level_result_t          result;
    } stim_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b1;
    logic [M_TDATA_W-1:0]   m_tdata;

    voiced_window_level_meter_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor copy of registers and state
    logic [LEN_W-1:0]   cur_len;
    logic [SUM_W-1:0]   cur_floor;
    logic [CREST_W-1:0] cur_crest;

    mode_t              mtr_mode;
    logic [SUM_W-1:0]   mtr_sum;
    logic [SAMPLE_W-1:0] mtr_peak;
    logic [LEN_W-1:0]   mtr_fill;
    logic               mtr_bad;
    logic [KCNT_W-1:0]  mtr_kept;
    logic [SUM_W-1:0]   mtr_store [WINDOWS_NEEDED];
    logic [SUM_W-1:0]   mtr_median;

    level_result_t      pending_levels [$];
    int                 mismatches = 0;
    int                 rand_count = 0;
    int                 burst_left = 1;
    int unsigned        rx_cycle = 0;
    int unsigned        rx_style = 0;
    int                 idle_cycles = 0;
    stim_row_t          directed_rows [N_DIRECTED];

    function automatic logic [SAMPLE_W-1:0] mag24(logic [SAMPLE_W-1:0] v);
        return v[SAMPLE_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic void clear_window();
        mtr_sum  = '0;
        mtr_peak = '0;
        mtr_fill = '0;
        mtr_bad  = 1'b0;
    endfunction

    function automatic level_result_t step_meter(func_t f, logic [SAMPLE_W-1:0] l,
                                                 logic [SAMPLE_W-1:0] r, logic inv);
        logic [SAMPLE_W-1:0] ml, mr;
        logic [63:0]         half, acc;
        logic [16:0]         n, len;
        logic [127:0]        lhs, rhs;
        logic [SUM_W-1:0]    srt [WINDOWS_NEEDED];
        logic [SUM_W-1:0]    tmp;
        level_result_t       res;
        int                  i, j;
        case (f)
            FUNC_START: begin
                mtr_kept = '0;
                clear_window();
                mtr_mode = MODE_LISTEN;
            end
            FUNC_CANCEL: begin
                if (mtr_mode == MODE_LISTEN) mtr_mode = MODE_IDLE;
            end
            FUNC_TAKE: mtr_mode = MODE_IDLE;
            default: begin
                if (mtr_mode == MODE_LISTEN) begin
                    ml = mag24(l);
                    mr = mag24(r);
                    half = ({40'd0, ml} * {40'd0, ml} + {40'd0, mr} * {40'd0, mr}) >> 1;
                    acc = {2'b00, mtr_sum} + half;
                    mtr_sum = (acc > {2'b00, SUM_MAX}) ? SUM_MAX : acc[SUM_W-1:0];
                    if (ml > mtr_peak) mtr_peak = ml;
                    if (mr > mtr_peak) mtr_peak = mr;
                    if (inv) mtr_bad = 1'b1;
                    n = {1'b0, mtr_fill} + 17'd1;
                    len = (cur_len == '0) ? 17'd1 : {1'b0, cur_len};
                    if (n >= len) begin
                        // crest test: peak^2 * n * 256 <= crest * sum, exact
                        lhs = {104'd0, mtr_peak};
                        lhs = lhs * lhs * {111'd0, n} * 128'd256;
                        rhs = {112'd0, cur_crest} * {66'd0, mtr_sum};
                        if (!mtr_bad && mtr_sum > cur_floor && lhs <= rhs &&
                            mtr_kept < WINDOWS_NEEDED) begin
                            mtr_store[mtr_kept] = mtr_sum;
                            mtr_kept = mtr_kept + 1'b1;
                            if (mtr_kept == WINDOWS_NEEDED) begin
                                for (i = 0; i < WINDOWS_NEEDED; i++) srt[i] = mtr_store[i];
                                for (i = 1; i < WINDOWS_NEEDED; i++) begin
                                    for (j = i; j > 0 && srt[j-1] > srt[j]; j--) begin
                                        tmp = srt[j];
                                        srt[j] = srt[j-1];
                                        srt[j-1] = tmp;
                                    end
                                end
                                mtr_median = srt[MEDIAN_RANK];
                                mtr_mode = MODE_DONE;
                            end
                        end
                        clear_window();
                    end else begin
                        mtr_fill = n[LEN_W-1:0];
                    end
                end
            end
        endcase
        res.mode   = mtr_mode;
        res.kept   = mtr_kept;
        res.median = mtr_median;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // drive one item and hold it until accepted; then the burst/gap pattern
    task automatic drive_item(func_t f, logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r,
                              logic inv, bit typed, level_result_t typed_res);
        level_result_t pred;
        int            gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {r, l};
        s_tuser  <= {inv, f};
        do @(posedge aclk); while (!s_tready);
        pred = step_meter(f, l, r, inv);
        pending_levels.push_back(typed ? typed_res : pred);
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
        end
    endtask

    task automatic rand_item(func_t f, logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r,
                             logic inv);
        // frames the block ignores do not count
        if (f != FUNC_FRAME || mtr_mode == MODE_LISTEN) rand_count++;
        drive_item(f, l, r, inv, 1'b0, '0);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= a;
        cfg_wr_data <= d;
        @(posedge aclk);
        case (a)
            REG_WINDOW_LENGTH: cur_len   = d[LEN_W-1:0];
            REG_FLOOR_SUM:     cur_floor = d[SUM_W-1:0];
            REG_CREST_RATIO:   cur_crest = d[CREST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [LEN_W-1:0] len, logic [SUM_W-1:0] flr,
                             logic [CREST_W-1:0] crest);
        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(len));
        write_reg(REG_FLOOR_SUM, flr);
        write_reg(REG_CREST_RATIO, CFG_DATA_W'(crest));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(int unsigned base, int unsigned jit);
        int unsigned         k, m;
        logic [SAMPLE_W-1:0] v;
        k = $urandom_range(0, 9);
        if (k < 7) begin
            // steady level with a little jitter, random sign
            m = base + ((jit != 0) ? $urandom_range(0, jit) : 0);
            if (m > 8388607) m = 8388607;
            v = SAMPLE_W'(m);
            if ($urandom_range(0, 1) != 0) v = -v;
        end else if (k == 7) begin
            case ($urandom_range(0, 4))
                0: v = 24'h800000;
                1: v = 24'h7FFFFF;
                2: v = 24'h000000;
                3: v = 24'hFFFFFF;
                default: v = 24'h000001;
            endcase
        end else begin
            v = SAMPLE_W'($urandom);
        end
        return v;
    endfunction

    // one listening session: optional start, frames with some command noise, optional end
    task automatic run_sequence(bit with_start);
        int unsigned base, jit, nfr, lim, k, eff_len;
        if (with_start)
            rand_item(FUNC_START, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'($urandom));
        base = $urandom_range(1, 8388607) >> $urandom_range(0, 20);
        if (base == 0) base = 1;
        jit = ($urandom_range(0, 2) == 0) ? 0 : (base >> $urandom_range(3, 8));
        eff_len = (cur_len == '0) ? 1 : cur_len;
        lim = (eff_len > 8) ? 200 : eff_len * 24;
        nfr = $urandom_range(4, lim);
        repeat (nfr) begin
            k = $urandom_range(0, 99);
            if (k < 3)
                rand_item(FUNC_CANCEL, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'($urandom));
            else if (k < 5)
                rand_item(FUNC_TAKE, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'($urandom));
            else if (k < 7)
                rand_item(FUNC_START, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'($urandom));
            else
                rand_item(FUNC_FRAME, pick_sample(base, jit), pick_sample(base, jit),
                          1'($urandom_range(0, 24) == 0));
        end
        k = $urandom_range(0, 9);
        if (k < 4)
            rand_item(FUNC_TAKE, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'($urandom));
        else if (k < 6)
            rand_item(FUNC_CANCEL, SAMPLE_W'($urandom), SAMPLE_W'($urandom), 1'($urandom));
    endtask

    // result checker
    always @(posedge aclk) begin
        level_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_levels.size() == 0) begin
                report_mismatch("unexpected result", 64'(m_tdata[M_FIELD_W-1:0]), 64'd0);
            end else begin
                want = pending_levels.pop_front();
                if (m_tdata[MODE_W-1:0] !== want.mode)
                    report_mismatch("mode", 64'(m_tdata[MODE_W-1:0]), 64'(want.mode));
                if (m_tdata[MODE_W +: KCNT_W] !== want.kept)
                    report_mismatch("windows_accepted", 64'(m_tdata[MODE_W +: KCNT_W]),
                                    64'(want.kept));
                if (m_tdata[MODE_W+KCNT_W +: SUM_W] !== want.median)
                    report_mismatch("median_sum", 64'(m_tdata[MODE_W+KCNT_W +: SUM_W]),
                                    64'(want.median));
            end
        end
    end

    // receiver stall pattern, in a randomly chosen style that changes periodically
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 600 == 0) rx_style <= $urandom_range(0, 3);
        case (rx_style)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_cycle % 7) >= 3;
            default: m_tready <= ($urandom_range(0, 15) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                 p, row;
        bit                 first;
        logic [LEN_W-1:0]   len;
        logic [SUM_W-1:0]   flr;
        logic [CREST_W-1:0] crest;

        cur_len    = WINDOW_LENGTH_RST;
        cur_floor  = '0;
        cur_crest  = CREST_RATIO_RST;
        mtr_mode   = MODE_IDLE;
        clear_window();
        mtr_kept   = '0;
        mtr_median = '0;

        // window length zero acts as one; crest 256 is the tightest ratio
        directed_rows = '{
            '{FUNC_TAKE,   24'h000000, 24'h000000, 1'b0, 1'b1, '{MODE_IDLE,   7'd0, 62'd0}},
            '{FUNC_CANCEL, 24'h000000, 24'h000000, 1'b0, 1'b1, '{MODE_IDLE,   7'd0, 62'd0}},
            '{FUNC_FRAME,  24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b1, '{MODE_IDLE,   7'd0, 62'd0}},
            '{FUNC_START,  24'h000000, 24'h000000, 1'b0, 1'b1, '{MODE_LISTEN, 7'd0, 62'd0}},
            '{FUNC_FRAME,  24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b1, '{MODE_LISTEN, 7'd1, 62'd0}},
            '{FUNC_FRAME,  24'h800000, 24'h800000, 1'b0, 1'b1, '{MODE_LISTEN, 7'd2, 62'd0}},
            // silent window never passes the floor
            '{FUNC_FRAME,  24'h000000, 24'h000000, 1'b0, 1'b1, '{MODE_LISTEN, 7'd2, 62'd0}},
            // corrupt frame drops its window
            '{FUNC_FRAME,  24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b1, '{MODE_LISTEN, 7'd2, 62'd0}},
            // one-sided full scale fails the crest limit
            '{FUNC_FRAME,  24'h7FFFFF, 24'h000000, 1'b0, 1'b1, '{MODE_LISTEN, 7'd2, 62'd0}},
            '{FUNC_FRAME,  24'h800000, 24'h7FFFFF, 1'b0, 1'b0, '{MODE_IDLE,   7'd0, 62'd0}},
            '{FUNC_FRAME,  24'hFFFFFF, 24'h000001, 1'b0, 1'b0, '{MODE_IDLE,   7'd0, 62'd0}},
            '{FUNC_FRAME,  24'h555555, 24'hAAAAAA, 1'b0, 1'b0, '{MODE_IDLE,   7'd0, 62'd0}},
            '{FUNC_CANCEL, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, '{MODE_IDLE,   7'd0, 62'd0}},
            '{FUNC_FRAME,  24'h123456, 24'h654321, 1'b1, 1'b0, '{MODE_IDLE,   7'd0, 62'd0}},
            '{FUNC_CANCEL, 24'h000000, 24'h000000, 1'b0, 1'b0, '{MODE_IDLE,   7'd0, 62'd0}},
            '{FUNC_START,  24'hAAAAAA, 24'h555555, 1'b1, 1'b0, '{MODE_IDLE,   7'd0, 62'd0}},
            '{FUNC_FRAME,  24'h123456, 24'hFEDCBA, 1'b0, 1'b0, '{MODE_IDLE,   7'd0, 62'd0}},
            '{FUNC_TAKE,   24'hFFFFFF, 24'h000000, 1'b1, 1'b0, '{MODE_IDLE,   7'd0, 62'd0}},
            '{FUNC_START,  24'h000000, 24'h000000, 1'b0, 1'b0, '{MODE_IDLE,   7'd0, 62'd0}},
            '{FUNC_TAKE,   24'h000000, 24'h000000, 1'b0, 1'b0, '{MODE_IDLE,   7'd0, 62'd0}}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        configure(16'd0, 62'd0, 16'd256);
        for (row = 0; row < N_DIRECTED; row++)
            drive_item(directed_rows[row].func, directed_rows[row].left,
                       directed_rows[row].right, directed_rows[row].invalid,
                       directed_rows[row].typed, directed_rows[row].result);

        // each phase resumes the open window first, so a shorter length can cut it
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin len = 16'd1;     flr = '0;      crest = 16'd65535; end
                1: begin len = 16'd3;     flr = '0;      crest = 16'd2560;  end
                3: begin len = 16'd0;     flr = '0;      crest = 16'd256;   end
                4: begin len = 16'd65535; flr = SUM_MAX; crest = 16'd65535; end
                5: begin len = 16'd2;     flr = SUM_W'(64'd1 << 40); crest = 16'd2560; end
                7: begin len = 16'd1;     flr = '0;      crest = 16'd256;   end
                9: begin len = 16'd4;     flr = '0;      crest = 16'd300;   end
                default: begin
                    len   = LEN_W'($urandom_range(1, 8));
                    flr   = SUM_W'({$urandom, $urandom}) >> $urandom_range(14, 40);
                    crest = CREST_W'($urandom_range(256, 65535));
                end
            endcase
            configure(len, flr, crest);
            first = 1'b1;
            while (rand_count < (p + 1) * ITEMS_PER_PHASE) begin
                run_sequence(!first);
                first = 1'b0;
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 4))
                        rand_item(func_t'($urandom_range(0, 3)), SAMPLE_W'($urandom),
                                  SAMPLE_W'($urandom), 1'($urandom));
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
